[rtl/core/lir_pkg.sv]
// Shared types and constants for the linear interpolation resampler.
// No dependencies; used by lir_front, lir_back and linear_interp_resampler.
package lir_pkg;

  localparam int unsigned Lanes       = 8;
  localparam int unsigned SampleBits  = 32;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned PosBits     = 24;
  localparam int unsigned StepBits    = 23;
  localparam int unsigned LaneCntBits = 4;
  localparam int unsigned ProdBits    = SampleBits + FracBits + 2;
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrBits    = 1;

  localparam logic [PosBits-1:0]  OnePos  = PosBits'(1 << FracBits);
  localparam logic [StepBits-1:0] MinStep = StepBits'(OnePos >> 5);

  typedef enum logic [1:0] {
    CfgInterpMode = 2'd0,
    CfgStep       = 2'd1,
    CfgChannels   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] in_ch0;
    logic signed [31:0] in_ch1;
    logic signed [31:0] in_ch2;
    logic signed [31:0] in_ch3;
    logic signed [31:0] in_ch4;
    logic signed [31:0] in_ch5;
    logic signed [31:0] in_ch6;
    logic signed [31:0] in_ch7;
    logic               end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_ch0;
    logic signed [31:0] out_ch1;
    logic signed [31:0] out_ch2;
    logic signed [31:0] out_ch3;
    logic signed [31:0] out_ch4;
    logic signed [31:0] out_ch5;
    logic signed [31:0] out_ch6;
    logic signed [31:0] out_ch7;
    logic               last_of_run;
  } out_item_t;

  typedef logic [Lanes-1:0][SampleBits-1:0] frame_t;

  typedef struct packed {
    frame_t smp;
    logic   eos;
  } q_item_t;

  typedef struct packed {
    logic                   interp;
    logic [StepBits-1:0]    step;
    logic [LaneCntBits-1:0] chans;
  } cfg_t;

endpackage

[rtl/core/linear_interp_resampler.sv]
// Top level of the linear interpolation resampler: configuration registers
// and the front/back pair. Depends on lir_pkg, lir_front and lir_back.
//
// Usage: frames go in on push_i/full_o, one multichannel frame per item,
// accepted when push_i is high and full_o low. Results come out on
// empty_o/pop_i; the oldest result sits on out_item_o while empty_o is low
// and leaves when pop_i is high. Each frame gives zero or more results,
// the last of them marked by last_of_run.
// Configuration writes use cfg_valid_i/cfg_ready_o (always ready) with a
// register index and data; they take effect at once and are meant to be
// made while the block is idle.
// A frame is written into the front queue; the back end takes it from
// there in its idle state, and each result passes the multiply state and
// the output state into the result register. The back end takes a new
// frame only when the results of the last one are all out.
// A two-entry queue sits between input and back end, so frames keep
// arriving while results wait. When the receiver stalls, the result
// register holds and the back end waits; the queue then fills and full_o
// rises. Reset clears the stored frame, the position, the queue and the
// result register and loads the defaults: linear mode, unit step, two lanes.
module linear_interp_resampler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  lir_pkg::in_item_t  in_item_i,
  output logic               empty_o,
  input  logic               pop_i,
  output lir_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  lir_pkg::cfg_t    cfg_q;
  logic             q_valid, q_pop;
  lir_pkg::q_item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interp <= 1'b1;
      cfg_q.step   <= lir_pkg::StepBits'(lir_pkg::OnePos);
      cfg_q.chans  <= lir_pkg::LaneCntBits'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lir_pkg::CfgInterpMode: cfg_q.interp <= cfg_data_i[0];
        lir_pkg::CfgStep:       cfg_q.step   <= cfg_data_i[lir_pkg::StepBits-1:0];
        lir_pkg::CfgChannels:   cfg_q.chans  <= cfg_data_i[lir_pkg::LaneCntBits-1:0];
        default:                cfg_q        <= cfg_q;
      endcase
    end
  end

  lir_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  lir_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

endmodule

[rtl/core/lir_front.sv]
// Input side: takes frames from the push channel and holds them in a
// two-entry queue for the back end. Depends on lir_pkg.
module lir_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  lir_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output lir_pkg::q_item_t  q_item_o
);

  lir_pkg::q_item_t                 mem_q [lir_pkg::QDepth];
  logic [lir_pkg::QPtrBits-1:0]     wr_ptr_q, rd_ptr_q;
  logic [lir_pkg::QPtrBits:0]       cnt_q;
  lir_pkg::q_item_t                 wr_item;
  logic                             do_push, do_pop;

  assign full_o    = (cnt_q == (lir_pkg::QPtrBits+1)'(lir_pkg::QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = q_pop_i & q_valid_o;
  assign q_item_o  = mem_q[rd_ptr_q];

  // sample width equals field width, so lanes are taken as they are
  always_comb begin
    wr_item.smp[0] = in_item_i.in_ch0;
    wr_item.smp[1] = in_item_i.in_ch1;
    wr_item.smp[2] = in_item_i.in_ch2;
    wr_item.smp[3] = in_item_i.in_ch3;
    wr_item.smp[4] = in_item_i.in_ch4;
    wr_item.smp[5] = in_item_i.in_ch5;
    wr_item.smp[6] = in_item_i.in_ch6;
    wr_item.smp[7] = in_item_i.in_ch7;
    wr_item.eos    = in_item_i.end_of_stream;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/core/lir_back.sv]
// Back end: walks the output positions of one frame, multiplies per lane,
// and fills the one-entry result register. Depends on lir_pkg.
module lir_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lir_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  lir_pkg::q_item_t   q_item_i,
  output logic               empty_o,
  input  logic               pop_i,
  output lir_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StOut  = 3'b100
  } state_e;

  localparam int unsigned SB = lir_pkg::SampleBits;
  localparam int unsigned FB = lir_pkg::FracBits;
  localparam int unsigned PB = lir_pkg::ProdBits;

  state_e                          state_q, state_d;
  logic                            hold_q, hold_d;
  logic                            eos_q, eos_d;
  logic                            have_prev_q, have_prev_d;
  logic [lir_pkg::PosBits-1:0]     pos_q, pos_d;
  lir_pkg::frame_t                 cur_q, cur_d;
  lir_pkg::frame_t                 prev_q, prev_d;
  logic [lir_pkg::Lanes-1:0][PB-1:0] prod_q, prod_d;
  lir_pkg::out_item_t              out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  logic [lir_pkg::PosBits-1:0]     step_eff, pos_sum, pos_rem, pos_adj;
  logic [lir_pkg::LaneCntBits-1:0] used;
  logic [lir_pkg::Lanes-1:0]       lane_act;
  logic [lir_pkg::Lanes-1:0][SB-1:0] val;
  logic                            can_load;

  assign step_eff = (cfg_i.step < lir_pkg::MinStep) ?
                    lir_pkg::PosBits'(lir_pkg::MinStep) :
                    lir_pkg::PosBits'(cfg_i.step);
  assign pos_sum  = pos_q + step_eff;
  assign pos_rem  = pos_sum - lir_pkg::OnePos;
  assign pos_adj  = pos_q - lir_pkg::OnePos;
  assign used     = (cfg_i.chans > lir_pkg::LaneCntBits'(lir_pkg::Lanes)) ?
                    lir_pkg::LaneCntBits'(lir_pkg::Lanes) : cfg_i.chans;
  assign can_load = ~out_valid_q | pop_i;
  assign empty_o    = ~out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    for (int j = 0; j < lir_pkg::Lanes; j++) begin
      lane_act[j] = (lir_pkg::LaneCntBits'(j) < used);
    end
  end

  // per-lane delta times fraction; prev*ONE is added in the next cycle
  always_comb begin
    logic signed [SB:0]   dlt;
    logic signed [FB:0]   fr;
    logic signed [PB-1:0] p;
    fr = $signed({1'b0, pos_q[FB-1:0]});
    for (int j = 0; j < lir_pkg::Lanes; j++) begin
      dlt = $signed({cur_q[j][SB-1], cur_q[j]}) - $signed({prev_q[j][SB-1], prev_q[j]});
      p   = PB'(dlt) * PB'(fr);
      prod_d[j] = p;
    end
  end

  // per lane: interpolated (truncated toward zero), prev, cur or zero
  always_comb begin
    logic signed [PB-1:0] num;
    logic signed [PB-1:0] shq;
    for (int j = 0; j < lir_pkg::Lanes; j++) begin
      num = $signed({{(PB-SB-FB){prev_q[j][SB-1]}}, prev_q[j], {FB{1'b0}}})
            + $signed(prod_q[j]);
      shq = num >>> FB;
      if (num[PB-1] && (num[FB-1:0] != '0)) shq = shq + PB'(1);
      if (!lane_act[j]) begin
        val[j] = '0;
      end else if (hold_q) begin
        val[j] = cur_q[j];
      end else if (!cfg_i.interp) begin
        val[j] = prev_q[j];
      end else begin
        val[j] = shq[SB-1:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    hold_d      = hold_q;
    eos_d       = eos_q;
    have_prev_d = have_prev_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~pop_i;
    q_pop_o     = 1'b0;

    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i.smp;
          eos_d   = q_item_i.eos;
          if (have_prev_q) begin
            if (pos_q < lir_pkg::OnePos) begin
              hold_d  = 1'b0;
              state_d = StMul;
            end else if (q_item_i.eos && (pos_adj < lir_pkg::OnePos)) begin
              hold_d  = 1'b1;
              pos_d   = pos_adj;
              state_d = StMul;
            end else begin
              prev_d      = q_item_i.smp;
              have_prev_d = ~q_item_i.eos;
              pos_d       = q_item_i.eos ? '0 : pos_adj;
            end
          end else if (q_item_i.eos) begin
            // lone frame that also ends the stream: repeat it
            hold_d  = 1'b1;
            state_d = StMul;
          end else begin
            prev_d      = q_item_i.smp;
            have_prev_d = 1'b1;
          end
        end
      end
      StMul: begin
        state_d = StOut;
      end
      StOut: begin
        if (can_load) begin
          out_valid_d         = 1'b1;
          out_d.out_ch0       = val[0];
          out_d.out_ch1       = val[1];
          out_d.out_ch2       = val[2];
          out_d.out_ch3       = val[3];
          out_d.out_ch4       = val[4];
          out_d.out_ch5       = val[5];
          out_d.out_ch6       = val[6];
          out_d.out_ch7       = val[7];
          out_d.last_of_run   = 1'b0;
          if (pos_sum < lir_pkg::OnePos) begin
            pos_d   = pos_sum;
            state_d = StMul;
          end else if (!hold_q && eos_q && (pos_rem < lir_pkg::OnePos)) begin
            hold_d  = 1'b1;
            pos_d   = pos_rem;
            state_d = StMul;
          end else begin
            out_d.last_of_run = 1'b1;
            prev_d            = cur_q;
            have_prev_d       = ~eos_q;
            pos_d             = eos_q ? '0 : pos_rem;
            state_d           = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    eos_q  <= eos_d;
    cur_q  <= cur_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      have_prev_q <= 1'b0;
      pos_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
